>>> rtl/core/sorted_interval_cue_table_assert.svh
// Assertion macros shared by the cue table modules.
`ifndef SORTED_INTERVAL_CUE_TABLE_ASSERT_SVH
`define SORTED_INTERVAL_CUE_TABLE_ASSERT_SVH

// Same-cycle implication, held off while reset is asserted.
`define SICT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sict assertion failed");

// Next-cycle implication, held off while reset is asserted.
`define SICT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sict assertion failed");

`endif

>>> rtl/core/sict_pkg.sv
package sict_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int TAG_BITS    = 16;

    localparam int TIME_W    = 36;
    localparam int IN_TAG_W  = 16;
    localparam int OUT_CNT_W = 9;
    localparam int IDX_W     = $clog2(TABLE_DEPTH);
    localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_W   = 2 * TIME_W + TAG_BITS;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_FOUND     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic    load;    // capture the incoming word
        logic    rd;      // read entry at scan index - 1
        logic    shift;   // move the read entry up to the scan index
        logic    dec;     // step the scan index down
        logic    place;   // write the new interval at the scan index
        logic    emit;    // present a result
        t_status code;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_lookup;
        logic full;
        logic empty;
        logic le;     // read start <= key
        logic hit;    // read entry covers the query time
        logic last;   // scan index is one
    } t_sts;

endpackage

>>> rtl/core/sict_ctrl.sv
module sict_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic            i_action,
    input  sict_pkg::t_sts  i_sts,
    output sict_pkg::t_cmd  o_cmd,
    output logic            busy
);

`include "sorted_interval_cue_table_assert.svh"

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_PLACE
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;
    sict_pkg::t_cmd cmd;

    always_comb begin
        n_state  = r_state;
        cmd      = '0;
        cmd.code = sict_pkg::ST_INSERTED;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    cmd.load = 1'b1;
                    if (!i_action) begin
                        if (i_sts.full) begin
                            cmd.emit = 1'b1;
                            cmd.code = sict_pkg::ST_FULL;
                        end else if (i_sts.empty) begin
                            n_state = S_PLACE;
                        end else begin
                            n_state = S_READ;
                        end
                    end else begin
                        if (i_sts.empty) begin
                            cmd.emit = 1'b1;
                            cmd.code = sict_pkg::ST_NOT_FOUND;
                        end else begin
                            n_state = S_READ;
                        end
                    end
                end
            end
            S_READ: begin
                cmd.rd  = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.is_lookup) begin
                    if (i_sts.hit) begin
                        cmd.emit = 1'b1;
                        cmd.code = sict_pkg::ST_FOUND;
                        n_state  = S_IDLE;
                    end else if (i_sts.last) begin
                        cmd.dec  = 1'b1;
                        cmd.emit = 1'b1;
                        cmd.code = sict_pkg::ST_NOT_FOUND;
                        n_state  = S_IDLE;
                    end else begin
                        cmd.dec = 1'b1;
                        n_state = S_READ;
                    end
                end else begin
                    if (i_sts.le) begin
                        n_state = S_PLACE;
                    end else begin
                        cmd.shift = 1'b1;
                        cmd.dec   = 1'b1;
                        n_state   = i_sts.last ? S_PLACE : S_READ;
                    end
                end
            end
            S_PLACE: begin
                cmd.place = 1'b1;
                cmd.emit  = 1'b1;
                cmd.code  = sict_pkg::ST_INSERTED;
                n_state   = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_cmd = cmd;
    assign busy  = r_busy;

    `SICT_ASSERT_NEXT(a_read_then_check, i_clk, i_rst_n, r_state == S_READ, r_state == S_CHECK)
    `SICT_ASSERT_NOW(a_busy_tracks_state, i_clk, i_rst_n, 1'b1, busy == (r_state != S_IDLE))
    `SICT_ASSERT_NOW(a_place_not_full, i_clk, i_rst_n, r_state == S_PLACE, !i_sts.full)

endmodule

>>> rtl/core/sict_dp.sv
module sict_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sict_pkg::t_cmd                    i_cmd,
    input  logic                              i_action,
    input  logic [sict_pkg::TIME_W-1:0]       i_start_ms,
    input  logic [sict_pkg::TIME_W-1:0]       i_end_ms,
    input  logic [sict_pkg::IN_TAG_W-1:0]     i_cue_tag,
    input  logic [sict_pkg::TIME_W-1:0]       i_query_ms,
    output sict_pkg::t_sts                    o_sts,
    output logic                              o_done,
    output logic [1:0]                        o_status,
    output logic [sict_pkg::IN_TAG_W-1:0]     o_found_tag,
    output logic [sict_pkg::OUT_CNT_W-1:0]    o_entry_count
);

`include "sorted_interval_cue_table_assert.svh"

    localparam int TW = sict_pkg::TIME_W;
    localparam int GW = sict_pkg::TAG_BITS;

    // entry word: {start, end, tag}
    logic [sict_pkg::ENTRY_W-1:0] r_mem [sict_pkg::TABLE_DEPTH];
    logic [sict_pkg::ENTRY_W-1:0] r_rd_data;

    logic [sict_pkg::CNT_W-1:0]   r_count, n_count;
    logic [sict_pkg::CNT_W-1:0]   r_idx;
    logic                         r_lookup;
    logic [TW-1:0]                r_key;
    logic [TW-1:0]                r_end;
    logic [GW-1:0]                r_tag;

    logic                         r_done;
    logic [1:0]                   r_status;
    logic [sict_pkg::IN_TAG_W-1:0]  r_found_tag;
    logic [sict_pkg::OUT_CNT_W-1:0] r_entry_count;

    logic [TW-1:0]                rd_start;
    logic [TW-1:0]                rd_end;
    logic [GW-1:0]                rd_tag;
    logic [sict_pkg::IDX_W-1:0]   rd_addr;
    logic [sict_pkg::IDX_W-1:0]   wr_addr;

    assign rd_start = r_rd_data[sict_pkg::ENTRY_W-1 -: TW];
    assign rd_end   = r_rd_data[GW +: TW];
    assign rd_tag   = r_rd_data[GW-1:0];
    assign rd_addr  = sict_pkg::IDX_W'(r_idx - sict_pkg::CNT_W'(1));
    assign wr_addr  = r_idx[sict_pkg::IDX_W-1:0];

    assign n_count = i_cmd.place ? r_count + sict_pkg::CNT_W'(1) : r_count;

    // table storage: one read port, one write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (i_cmd.shift) begin
            r_mem[wr_addr] <= r_rd_data;
        end else if (i_cmd.place) begin
            r_mem[wr_addr] <= {r_key, r_end, r_tag};
        end
    end

    // item capture and scan index
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lookup <= i_action;
            r_key    <= i_action ? i_query_ms : i_start_ms;
            r_end    <= i_end_ms;
            r_tag    <= GW'(i_cue_tag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_idx         <= '0;
            r_done        <= 1'b0;
            r_status      <= '0;
            r_found_tag   <= '0;
            r_entry_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_cmd.load) begin
                r_idx <= r_count;
            end else if (i_cmd.dec) begin
                r_idx <= r_idx - sict_pkg::CNT_W'(1);
            end
            r_done <= i_cmd.emit;
            if (i_cmd.emit) begin
                r_status      <= i_cmd.code;
                r_found_tag   <= (i_cmd.code == sict_pkg::ST_FOUND) ?
                                 sict_pkg::IN_TAG_W'(rd_tag) : '0;
                r_entry_count <= sict_pkg::OUT_CNT_W'(n_count);
            end
        end
    end

    always_comb begin
        o_sts           = '0;
        o_sts.is_lookup = r_lookup;
        o_sts.full      = (r_count == sict_pkg::CNT_W'(sict_pkg::TABLE_DEPTH));
        o_sts.empty     = (r_count == '0);
        o_sts.le        = (rd_start <= r_key);
        o_sts.hit       = (rd_start <= r_key) && (r_key < rd_end);
        o_sts.last      = (r_idx == sict_pkg::CNT_W'(1));
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_found_tag   = r_found_tag;
    assign o_entry_count = r_entry_count;

    `SICT_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= sict_pkg::CNT_W'(sict_pkg::TABLE_DEPTH))
    `SICT_ASSERT_NEXT(a_place_grows, i_clk, i_rst_n, i_cmd.place, r_count == $past(r_count) + sict_pkg::CNT_W'(1))
    `SICT_ASSERT_NOW(a_shift_in_range, i_clk, i_rst_n, i_cmd.shift, (r_idx <= r_count) && (r_idx != '0))

endmodule

>>> rtl/core/sorted_interval_cue_table.sv
// A full-table insert or an empty-table lookup is answered from idle with no scan; any other
// lookup reads entries from the top until one covers the query time or slot 0 is read, and an
// insert into a non-empty table moves entries up until one at or below its start stops the scan.
// Throughput: one word at a time; busy holds off the next word until the result cycle, while
// the scan reads and tests one entry at a time.
// Reset: synchronous active low; empties the table, no clearing pass; receiver cannot stall.
module sorted_interval_cue_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_action,
    input  logic [sict_pkg::TIME_W-1:0]       i_start_ms,
    input  logic [sict_pkg::TIME_W-1:0]       i_end_ms,
    input  logic [sict_pkg::IN_TAG_W-1:0]     i_cue_tag,
    input  logic [sict_pkg::TIME_W-1:0]       i_query_ms,
    output logic                              o_done,
    output logic [1:0]                        o_status,
    output logic [sict_pkg::IN_TAG_W-1:0]     o_found_tag,
    output logic [sict_pkg::OUT_CNT_W-1:0]    o_entry_count
);

    // The table is kept sorted by start time in one memory of {start, end, tag}.
    // Both operations scan downward from the top entry:
    //  - insert: each entry with a start above the new one moves up a slot;
    //    the first entry at or below stops the scan and the new word lands above it.
    //  - lookup: the first entry from the top that covers the query time wins,
    //    which is the match with the latest start, the latest-placed among equal starts.
    sict_pkg::t_cmd cmd;
    sict_pkg::t_sts sts;

    sict_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_action),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    sict_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_action      (i_action),
        .i_start_ms    (i_start_ms),
        .i_end_ms      (i_end_ms),
        .i_cue_tag     (i_cue_tag),
        .i_query_ms    (i_query_ms),
        .o_sts         (sts),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_found_tag   (o_found_tag),
        .o_entry_count (o_entry_count)
    );

endmodule

>>> dv/tb_sorted_interval_cue_table.sv
module tb_sorted_interval_cue_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = sict_pkg::TABLE_DEPTH;
    localparam int TAG_BITS    = sict_pkg::TAG_BITS;
    localparam int TIME_W      = sict_pkg::TIME_W;
    localparam int IN_TAG_W    = sict_pkg::IN_TAG_W;
    localparam int OUT_CNT_W   = sict_pkg::OUT_CNT_W;

    // action codes of an input word
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    localparam int N_RANDOM  = 1430;
    localparam int MAX_GAP   = 48;
    localparam int NEAR_SPAN = 4000;   // most cue times fall in this small window
    localparam int TAIL_WAIT = 2 * TABLE_DEPTH + 8;

    localparam logic [TIME_W-1:0] T_MAX = '1;

    typedef struct {
        logic                action;
        logic [TIME_W-1:0]   start_ms;
        logic [TIME_W-1:0]   end_ms;
        logic [IN_TAG_W-1:0] cue_tag;
        logic [TIME_W-1:0]   query_ms;
        int unsigned         gap;      // idle cycles after this word is taken
        bit                  drain;    // hold this word until all results are back
    } t_cue_word;

    typedef struct {
        sict_pkg::t_status    status;
        logic [IN_TAG_W-1:0]  tag;
        logic [OUT_CNT_W-1:0] count;
    } t_cue_result;

    // clock, reset and DUT pins; every input starts at a known value
    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 start      = 1'b0;
    logic                 busy;
    logic                 i_action   = 1'b0;
    logic [TIME_W-1:0]    i_start_ms = '0;
    logic [TIME_W-1:0]    i_end_ms   = '0;
    logic [IN_TAG_W-1:0]  i_cue_tag  = '0;
    logic [TIME_W-1:0]    i_query_ms = '0;
    logic                 o_done;
    logic [1:0]           o_status;
    logic [IN_TAG_W-1:0]  o_found_tag;
    logic [OUT_CNT_W-1:0] o_entry_count;

    sorted_interval_cue_table u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_start_ms    (i_start_ms),
        .i_end_ms      (i_end_ms),
        .i_cue_tag     (i_cue_tag),
        .i_query_ms    (i_query_ms),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_found_tag   (o_found_tag),
        .o_entry_count (o_entry_count)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shadow of the cue table: sorted by start, ties kept in arrival order
    // ------------------------------------------------------------------
    logic [TIME_W-1:0]   cue_start [TABLE_DEPTH];
    logic [TIME_W-1:0]   cue_end   [TABLE_DEPTH];
    logic [TAG_BITS-1:0] cue_tag   [TABLE_DEPTH];
    int                  cue_held = 0;

    t_cue_word   word_q [$];     // words still to send
    t_cue_result result_q [$];   // results owed by the DUT, oldest first
    t_cue_word   cur_word;
    t_cue_result want;
    int unsigned gap_left = 0;
    int          err_count = 0;
    longint      cycle_cnt = 0;
    longint      cycle_limit = 64'd4000000;

    // generator bookkeeping
    logic [TIME_W-1:0] bounds [$];   // starts and ends handed out so far
    int                gen_inserts = 0;
    int                burst_left = 0;
    bit                drain_next = 0;

    // Apply one word to the shadow table and return the result it owes.
    function automatic t_cue_result apply_word(t_cue_word w);
        t_cue_result r;
        int          pos;
        int          i;
        r.status = sict_pkg::ST_NOT_FOUND;
        r.tag    = '0;
        if (w.action == ACT_INSERT) begin
            if (cue_held >= TABLE_DEPTH) begin
                r.status = sict_pkg::ST_FULL;
            end else begin
                // new entry goes after every entry with start <= its start
                pos = 0;
                while (pos < cue_held && cue_start[pos] <= w.start_ms) pos++;
                for (i = cue_held; i > pos; i--) begin
                    cue_start[i] = cue_start[i-1];
                    cue_end[i]   = cue_end[i-1];
                    cue_tag[i]   = cue_tag[i-1];
                end
                cue_start[pos] = w.start_ms;
                cue_end[pos]   = w.end_ms;
                cue_tag[pos]   = w.cue_tag[TAG_BITS-1:0];
                cue_held++;
                r.status = sict_pkg::ST_INSERTED;
            end
        end else begin
            // walk back from the last entry starting at or before the query
            pos = 0;
            while (pos < cue_held && cue_start[pos] <= w.query_ms) pos++;
            while (pos > 0) begin
                pos--;
                if (w.query_ms < cue_end[pos]) begin
                    r.status = sict_pkg::ST_FOUND;
                    r.tag    = IN_TAG_W'(cue_tag[pos]);
                    break;
                end
            end
        end
        r.count = OUT_CNT_W'(cue_held);
        return r;
    endfunction

    function automatic logic [TIME_W-1:0] rand_time();
        return TIME_W'({$urandom, $urandom});
    endfunction

    // mostly back to back or short gaps, now and then a long one,
    // and runs of words with no gap at all
    function automatic int unsigned next_gap();
        int unsigned r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(99, 0);
        if (r < 4) begin
            burst_left = $urandom_range(60, 20);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 82) return $urandom_range(3, 1);
        if (r < 96) return $urandom_range(12, 4);
        return $urandom_range(MAX_GAP, 20);
    endfunction

    // unused fields of each word carry random noise
    task automatic queue_word(logic act, logic [TIME_W-1:0] s, logic [TIME_W-1:0] e,
                              logic [IN_TAG_W-1:0] tag, logic [TIME_W-1:0] q);
        t_cue_word w;
        w.action   = act;
        w.start_ms = (act == ACT_INSERT) ? s   : rand_time();
        w.end_ms   = (act == ACT_INSERT) ? e   : rand_time();
        w.cue_tag  = (act == ACT_INSERT) ? tag : IN_TAG_W'($urandom);
        w.query_ms = (act == ACT_LOOKUP) ? q   : rand_time();
        w.gap      = next_gap();
        w.drain    = drain_next;
        drain_next = 0;
        if (act == ACT_INSERT) begin
            gen_inserts++;
            bounds.push_back(s);
            bounds.push_back(e);
        end
        word_q.push_back(w);
    endtask

    task automatic queue_random_insert();
        logic [TIME_W-1:0] s;
        logic [TIME_W-1:0] e;
        int unsigned       r;
        r = $urandom_range(99, 0);
        if (r < 10) begin
            s = rand_time();
            e = rand_time();
        end else begin
            // reuse a known time now and then to get equal starts
            if (r < 25 && bounds.size() != 0)
                s = bounds[$urandom_range(bounds.size() - 1, 0)];
            else
                s = TIME_W'($urandom_range(NEAR_SPAN, 0));
            r = $urandom_range(99, 0);
            if (r < 6)       e = s;                                         // empty interval
            else if (r < 12) e = s - TIME_W'($urandom_range(50, 1));        // inverted interval
            else if (r < 17) e = s + TIME_W'(1);
            else             e = s + TIME_W'($urandom_range(600, 2));
        end
        queue_word(ACT_INSERT, s, e, IN_TAG_W'($urandom), '0);
    endtask

    task automatic queue_random_lookup();
        logic [TIME_W-1:0] q;
        int unsigned       r;
        r = $urandom_range(99, 0);
        if (r < 60 && bounds.size() != 0) begin
            // just below, on, or just past a known boundary
            q = bounds[$urandom_range(bounds.size() - 1, 0)]
                + TIME_W'($urandom_range(2, 0)) - TIME_W'(1);
        end else if (r < 90) begin
            q = TIME_W'($urandom_range(NEAR_SPAN + 700, 0));
        end else begin
            q = rand_time();
        end
        queue_word(ACT_LOOKUP, '0, '0, '0, q);
    endtask

    // ------------------------------------------------------------------
    // Driver: one word on the pins at a time, held until start && !busy
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left <= 0;
        end else begin
            if (start && !busy) begin
                result_q.push_back(apply_word(cur_word));
            end
            if (!start || !busy) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    start    <= 1'b0;
                end else if (word_q.size() == 0) begin
                    start <= 1'b0;
                end else if (word_q[0].drain && result_q.size() != 0) begin
                    start <= 1'b0;    // hold until the DUT has answered everything
                end else begin
                    cur_word   = word_q.pop_front();
                    i_action   <= cur_word.action;
                    i_start_ms <= cur_word.start_ms;
                    i_end_ms   <= cur_word.end_ms;
                    i_cue_tag  <= cur_word.cue_tag;
                    i_query_ms <= cur_word.query_ms;
                    start      <= 1'b1;
                    gap_left   <= cur_word.gap;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every o_done cycle is checked against the oldest result owed
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (result_q.size() == 0) begin
                $error("unexpected result: status %0d tag %0h count %0d",
                       o_status, o_found_tag, o_entry_count);
                err_count++;
            end else begin
                want = result_q.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    err_count++;
                end
                if (o_found_tag !== want.tag) begin
                    $error("found_tag: expected %0h, got %0h", want.tag, o_found_tag);
                    err_count++;
                end
                if (o_entry_count !== want.count) begin
                    $error("entry_count: expected %0d, got %0d", want.count, o_entry_count);
                    err_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > cycle_limit) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        // directed: empty table, time extremes, ties, overlaps, empty and inverted
        queue_word(ACT_LOOKUP, '0, '0, '0, '0);
        queue_word(ACT_LOOKUP, '0, '0, '0, T_MAX);
        queue_word(ACT_INSERT, '0, T_MAX, 16'hFFFF, '0);
        queue_word(ACT_INSERT, T_MAX, '0, 16'h0000, '0);
        queue_word(ACT_INSERT, 36'd100, 36'd100, 16'h1234, '0);
        queue_word(ACT_INSERT, 36'd100, 36'd200, 16'hA5A5, '0);
        queue_word(ACT_INSERT, 36'd50, 36'd300, 16'h5A5A, '0);
        queue_word(ACT_INSERT, 36'd100, 36'd150, 16'h0001, '0);
        queue_word(ACT_INSERT, T_MAX - 1, T_MAX, 16'h8000, '0);
        queue_word(ACT_LOOKUP, '0, '0, '0, '0);
        queue_word(ACT_LOOKUP, '0, '0, '0, 36'd49);
        queue_word(ACT_LOOKUP, '0, '0, '0, 36'd100);
        queue_word(ACT_LOOKUP, '0, '0, '0, 36'd149);
        queue_word(ACT_LOOKUP, '0, '0, '0, 36'd150);
        queue_word(ACT_LOOKUP, '0, '0, '0, 36'd200);
        queue_word(ACT_LOOKUP, '0, '0, '0, 36'd299);
        queue_word(ACT_LOOKUP, '0, '0, '0, 36'd300);
        queue_word(ACT_LOOKUP, '0, '0, '0, T_MAX - 1);
        queue_word(ACT_LOOKUP, '0, '0, '0, T_MAX);

        // random: fill the table under a lookup mix, then keep hammering it full
        drain_next = 1;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (gen_inserts == TABLE_DEPTH || n == N_RANDOM - 400) drain_next = 1;
            if (gen_inserts < TABLE_DEPTH) begin
                if ($urandom_range(1, 0) == 0) queue_random_insert();
                else                           queue_random_lookup();
            end else begin
                if ($urandom_range(4, 0) == 0) queue_random_insert();   // dropped, full
                else                           queue_random_lookup();
            end
        end

        // worst case per word: full scan, longest gap, several times over
        cycle_limit = longint'(word_q.size()) * (2 * TABLE_DEPTH + 4 + MAX_GAP) * 4 + 20000;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(word_q.size() == 0 && !start && result_q.size() == 0)) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);

        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/sict_pkg.sv
rtl/core/sict_ctrl.sv
rtl/core/sict_dp.sv
rtl/core/sorted_interval_cue_table.sv
dv/tb_sorted_interval_cue_table.sv
